### design/assert_macros.svh
// Assertion macros used by the controller design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define ACIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define ACIC_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ACIC_ASSERT(lbl, clk, rst_n, prop)
`define ACIC_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### design/acic_pkg.sv
// Types and constants of the averaged current integral controller.
package acic_pkg;

  localparam int DATA_W      = 16;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int INTEG_W     = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int GAIN_FRAC_W = 8;

  localparam int AVG_SAMPLES_DEF = 10;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd6000;

  typedef enum logic [0:0] {
    CFG_GAIN  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] current_ma;
    logic signed [DATA_W-1:0] desired_ma;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_mv;
    logic signed [DATA_W-1:0] average_ma;
  } out_item_t;

endpackage

### design/averaged_current_integral_control.sv
// Top level of the averaged current integral controller.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid / in_ready  | in_data: current_ma, desired_ma
//   out     | output    | out_valid/out_ready  | out_data: drive_mv, average_ma
//   cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item is accepted per clock cycle while the pipeline does not stall. An item
// that closes a window of AVG_SAMPLES samples gives one result item, carried by the
// five register stages from the window sum to the output register.
// Other items give no result. All stages advance together, and they stall only
// while a result waits in the output register with out_ready low and the next
// result has already reached the last stage.
// Reset (synchronous, active low) clears the window, the integrator and all
// valid flags and loads the gain and limit reset values; cfg_ready stays high.
`include "assert_macros.svh"

module averaged_current_integral_control #(
  parameter int AVG_SAMPLES = acic_pkg::AVG_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  acic_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output acic_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  acic_pkg::cfg_reg_t                   cfg_index,
  input  logic [acic_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DATA_W  = acic_pkg::DATA_W;
  localparam int INTEG_W = acic_pkg::INTEG_W;
  localparam int GAIN_W  = acic_pkg::GAIN_W;
  localparam int LIMIT_W = acic_pkg::LIMIT_W;
  localparam int FRAC_W  = acic_pkg::GAIN_FRAC_W;

  // The window sum grows by log2 of the window length over one sample.
  localparam int LOG_W   = $clog2(AVG_SAMPLES);
  localparam int SUM_W   = DATA_W + LOG_W;
  localparam int CNT_W   = $clog2(AVG_SAMPLES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_SAMPLES - 1);

  // Division by the window length is a multiplication by a rounded-up
  // reciprocal, exact for every magnitude of SUM_W bits.
  localparam int SHIFT   = SUM_W + LOG_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int QPROD_W = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  localparam int ACC_W  = INTEG_W + 2;
  localparam int PRD_W  = GAIN_W + 1 + INTEG_W;
  localparam int DRV_W  = PRD_W + 1 - FRAC_W;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_r;
  logic [LIMIT_W-1:0] limit_r;

  // Window and integrator state.
  logic [SUM_W-1:0]          sum_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [INTEG_W-1:0] integral_r;

  // Pipeline valid flags.
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;

  // Pipeline payload.
  logic [SUM_W-1:0]          s1_sum_r;
  logic signed [DATA_W-1:0]  s1_want_r;
  logic [DATA_W-1:0]         s2_quot_r;
  logic                      s2_neg_r;
  logic signed [DATA_W-1:0]  s2_want_r;
  logic signed [DATA_W-1:0]  s3_avg_r;
  logic                      s3_want_zero_r;
  logic signed [PRD_W-1:0]   s4_prod_r;
  logic signed [DATA_W-1:0]  s4_avg_r;
  logic                      s4_want_zero_r;
  acic_pkg::out_item_t       out_r;

  logic                      en;
  logic                      in_fire;
  logic                      win_close;
  logic [SUM_W-1:0]          cur_ext;
  logic [SUM_W-1:0]          sum_nxt;
  logic [SUM_W-1:0]          s1_mag;
  logic [QPROD_W-1:0]        quot_full;
  logic [DATA_W:0]           quot_ext;
  logic [DATA_W:0]           avg_ext;
  logic signed [DATA_W-1:0]  avg;
  logic signed [DATA_W:0]    diff;
  logic signed [ACC_W-1:0]   acc;
  logic signed [INTEG_W-1:0] integral_nxt;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [PRD_W-1:0]   prod;
  logic signed [PRD_W:0]     neg_prod;
  logic signed [DRV_W-1:0]   drv_full;
  logic signed [DRV_W-1:0]   lim_pos;
  logic signed [DRV_W-1:0]   lim_neg;
  logic signed [DRV_W-1:0]   drv_clamp;
  logic signed [DATA_W-1:0]  drive_nxt;

  // The pipeline moves unless the last stage holds a result that cannot
  // enter the output register because a result still waits there.
  assign en        = !(s4_valid_r && out_valid_r && !out_ready);
  assign in_ready  = en;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Window accumulation: the item on the last count closes the window.
  assign cur_ext   = SUM_W'(in_data.current_ma);
  assign sum_nxt   = sum_r + cur_ext;
  assign win_close = (cnt_r == LAST_CNT);

  // Magnitude of the closed sum times the reciprocal gives the quotient.
  assign s1_mag    = s1_sum_r[SUM_W-1] ? (~s1_sum_r + SUM_W'(1)) : s1_sum_r;
  assign quot_full = QPROD_W'(s1_mag) * QPROD_W'(RECIP);

  // Sign restore truncates toward zero; then the saturating integrator.
  assign quot_ext = {1'b0, s2_quot_r};
  assign avg_ext  = s2_neg_r ? (~quot_ext + (DATA_W+1)'(1)) : quot_ext;
  assign avg      = $signed(avg_ext[DATA_W-1:0]);
  assign diff     = (DATA_W+1)'(avg) - (DATA_W+1)'(s2_want_r);
  assign acc      = ACC_W'(integral_r) + ACC_W'(diff);

  always_comb begin
    if (acc[ACC_W-1:INTEG_W-1] == '0 || acc[ACC_W-1:INTEG_W-1] == '1) begin
      integral_nxt = acc[INTEG_W-1:0];
    end else if (acc[ACC_W-1]) begin
      integral_nxt = INTEG_MIN;
    end else begin
      integral_nxt = INTEG_MAX;
    end
  end

  // Gain times the freshly updated integral.
  assign gain_s = $signed({1'b0, gain_r});
  assign prod   = PRD_W'(gain_s) * PRD_W'(integral_r);

  // Negate, floor-shift by the gain's fraction bits and clamp.
  assign neg_prod = -((PRD_W+1)'(s4_prod_r));
  assign drv_full = $signed(neg_prod[PRD_W:FRAC_W]);
  assign lim_pos  = $signed(DRV_W'({1'b0, limit_r}));
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (drv_full > lim_pos) begin
      drv_clamp = lim_pos;
    end else if (drv_full < lim_neg) begin
      drv_clamp = lim_neg;
    end else begin
      drv_clamp = drv_full;
    end
    // A zero target forces the drive to zero.
    if (s4_want_zero_r) begin
      drive_nxt = '0;
    end else begin
      drive_nxt = drv_clamp[DATA_W-1:0];
    end
  end

  // Control state, integrator and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= acic_pkg::GAIN_RESET;
      limit_r     <= acic_pkg::LIMIT_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      integral_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (win_close) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (en) begin
        s1_valid_r  <= in_fire && win_close;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        s4_valid_r  <= s3_valid_r;
        if (s2_valid_r) begin
          integral_r <= integral_nxt;
        end
      end
      // The output register fills from the last stage and empties when taken.
      if (en && s4_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          acic_pkg::CFG_GAIN: begin
            gain_r <= cfg_data;
          end
          acic_pkg::CFG_LIMIT: begin
            limit_r <= cfg_data[LIMIT_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Pipeline payload needs no reset; the valid flags qualify it.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum_r       <= sum_nxt;
      s1_want_r      <= in_data.desired_ma;
      s2_quot_r      <= quot_full[SHIFT +: DATA_W];
      s2_neg_r       <= s1_sum_r[SUM_W-1];
      s2_want_r      <= s1_want_r;
      s3_avg_r       <= avg;
      s3_want_zero_r <= (s2_want_r == '0);
      s4_prod_r      <= prod;
      s4_avg_r       <= s3_avg_r;
      s4_want_zero_r <= s3_want_zero_r;
    end
    if (en && s4_valid_r) begin
      out_r.drive_mv   <= drive_nxt;
      out_r.average_ma <= s4_avg_r;
    end
  end

  // The sample count never passes the last position of a window.
  `ACIC_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= LAST_CNT)

  // An item that closes a window restarts the count and starts a result.
  `ACIC_ASSERT(a_win_restart, clk, rst_n,
               (in_fire && win_close) |=> (s1_valid_r && cnt_r == '0 && sum_r == '0))

  // The integrator moves only when a window average advances through it.
  `ACIC_ASSERT(a_integ_hold, clk, rst_n, !(en && s2_valid_r) |=> $stable(integral_r))

  // A new result only appears when the last stage held one.
  `ACIC_NEVER(a_out_origin, clk, rst_n, $rose(out_valid_r) && !$past(s4_valid_r))

endmodule

### verif/acic_tb_pkg.sv
// Scoreboard class that predicts and checks the controller's drive results.
`timescale 1ns / 1ps

package acic_tb_pkg;
  import acic_pkg::*;

  localparam int     WINDOW      = AVG_SAMPLES_DEF;
  localparam longint INTEG_MAX   = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN   = -(longint'(1) <<< (INTEG_W - 1));
  localparam int     MAX_PRINTED = 50;

  class drive_scoreboard;
    logic [GAIN_W-1:0]  gain_q8;
    logic [LIMIT_W-1:0] limit_mv;
    longint             window_sum;
    int                 window_fill;
    longint             error_integral;
    out_item_t          expected_drives[$];
    int                 mismatches;
    int                 samples_seen;
    int                 drives_checked;
    int                 zero_target_windows;
    int                 integ_limit_hits;

    function new();
      gain_q8             = GAIN_RESET;
      limit_mv            = LIMIT_RESET;
      window_sum          = 0;
      window_fill         = 0;
      error_integral      = 0;
      mismatches          = 0;
      samples_seen        = 0;
      drives_checked      = 0;
      zero_target_windows = 0;
      integ_limit_hits    = 0;
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    function void note_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_GAIN:  gain_q8  = value[GAIN_W-1:0];
        CFG_LIMIT: limit_mv = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Adds one sample to the window; a full window yields one expected result.
    function void note_sample(in_item_t item);
      longint    avg;
      longint    acc;
      longint    prod;
      longint    drive;
      longint    lim;
      out_item_t exp_item;
      samples_seen++;
      window_sum += longint'($signed(item.current_ma));
      window_fill++;
      if (window_fill < WINDOW) return;

      // Signed division truncates toward zero, as the average requires.
      avg = window_sum / WINDOW;
      acc = error_integral + avg - longint'($signed(item.desired_ma));
      if (acc > INTEG_MAX) begin
        acc = INTEG_MAX;
        integ_limit_hits++;
      end
      if (acc < INTEG_MIN) begin
        acc = INTEG_MIN;
        integ_limit_hits++;
      end
      error_integral = acc;

      // Arithmetic shift of the negated product gives the floor division.
      prod  = longint'(gain_q8) * error_integral;
      drive = (-prod) >>> GAIN_FRAC_W;
      lim   = longint'(limit_mv);
      if (drive > lim) drive = lim;
      if (drive < -lim) drive = -lim;
      if (item.desired_ma == '0) begin
        drive = 0;
        zero_target_windows++;
      end

      exp_item.drive_mv   = drive[DATA_W-1:0];
      exp_item.average_ma = avg[DATA_W-1:0];
      expected_drives.push_back(exp_item);
      window_sum  = 0;
      window_fill = 0;
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_drive(out_item_t got);
      out_item_t want;
      drives_checked++;
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("result with none expected: drive %0d average %0d",
                                  got.drive_mv, got.average_ma));
        return;
      end
      want = expected_drives.pop_front();
      if (got.drive_mv !== want.drive_mv)
        report_mismatch($sformatf("drive_mv got %0d, wanted %0d",
                                  got.drive_mv, want.drive_mv));
      if (got.average_ma !== want.average_ma)
        report_mismatch($sformatf("average_ma got %0d, wanted %0d",
                                  got.average_ma, want.average_ma));
    endtask
  endclass

endpackage

### verif/tb.sv
// Testbench top for the averaged current integral controller.
`timescale 1ns / 1ps

module tb;
  import acic_pkg::*;
  import acic_tb_pkg::*;

  // Settling pause used before register writes and at the end of the run.
  localparam int     SETTLE_CYCLES = 8;
  localparam longint TIMEOUT_NS    = 20_000_000;
  localparam int     NUM_PHASES    = 6;
  // A few full-scale windows at full rate for the closing phase.
  localparam int     SAT_WINDOWS   = 3;

  typedef struct {
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] limit;
    int                    send_idle;
    int                    recv_stall;
    int                    items;
  } phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drive_scoreboard sb = new();
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              window_slot    = 0;

  averaged_current_integral_control u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver decides at each falling edge whether it takes a result at
  // the next rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitors sample every channel at the rising edge, so the scoreboard sees
  // accepted items, register writes and results in the order the block does.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
    if (rst_n && in_valid && in_ready) sb.note_sample(in_data);
    if (rst_n && out_valid && out_ready) sb.check_drive(out_data);
  end

  // Clips both fields into the signed 16-bit range of the input item.
  function automatic in_item_t make_item(int cur, int want);
    in_item_t item;
    if (cur > 32767) cur = 32767;
    if (cur < -32768) cur = -32768;
    if (want > 32767) want = 32767;
    if (want < -32768) want = -32768;
    item.current_ma = cur[DATA_W-1:0];
    item.desired_ma = want[DATA_W-1:0];
    return item;
  endfunction

  // Presents one item after an optional random gap and holds it until the
  // block accepts it. The window position is tracked here so that the random
  // part knows which sample closes a window.
  task automatic send_item(input in_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    window_slot = (window_slot + 1) % WINDOW;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender back until every expected result has arrived, then lets
  // any sample that closes no window pass through the pipeline as well.
  task automatic wait_until_settled();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("averaged_current_integral_control: mismatch");
    $finish;
  end

  initial begin
    phase_t   plan [NUM_PHASES];
    int       level;
    int       spread;
    int       cur;
    int       want;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAIN;
    cfg_data  = '0;
    level     = 0;
    spread    = 0;

    // Register settings and idling per phase. The extremes come first; the
    // write of all ones to the limit checks that only its low 15 bits count.
    plan[0] = '{16'd0, 16'd32767, 0, 0, 80};
    plan[1] = '{16'hFFFF, 16'd0, 82, 0, 80};
    plan[2] = '{16'hFFFF, 16'hFFFF, 0, 82, 80};
    plan[3] = '{16'($urandom_range(65535)), 16'($urandom_range(32767)), 28, 28, 100};
    plan[4] = '{16'd1, 16'd1, 0, 0, 80};
    plan[5] = '{16'($urandom_range(1023)), 16'($urandom_range(32767)), 28, 28, 80};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values. The first window sits at
    // the positive extreme with a lowered last sample, so the average must
    // truncate to 32766, and a most negative target drives the drive into
    // its negative clamp.
    for (int k = 0; k < WINDOW; k++) begin
      send_item(make_item((k == WINDOW - 1) ? 32766 : 32767,
                          (k == WINDOW - 1) ? -32768 : ((k % 2) ? 32767 : -32768)));
    end
    // The second window sits at the negative extreme with one sample raised,
    // so the average must truncate toward zero to -32767. Its target is zero,
    // which forces the drive to zero while the integrator still moves.
    for (int k = 0; k < WINDOW; k++) begin
      send_item(make_item((k == 0) ? -32767 : -32768,
                          (k == WINDOW - 1) ? 0 : ((k % 2) ? -32768 : 32767)));
    end

    // Random phases. Each window follows a level with a chosen spread, and
    // the closing target usually lies near that level so the integrator stays
    // in a range where the drive is not always clamped. A share of samples
    // and targets are pure noise, and some targets are zero.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_until_settled();
      if ($urandom_range(1)) begin
        write_reg(CFG_GAIN, plan[p].gain);
        write_reg(CFG_LIMIT, plan[p].limit);
      end else begin
        write_reg(CFG_LIMIT, plan[p].limit);
        write_reg(CFG_GAIN, plan[p].gain);
      end
      send_idle_pct  = plan[p].send_idle;
      recv_stall_pct = plan[p].recv_stall;
      for (int n = 0; n < plan[p].items; n++) begin
        if (window_slot == 0) begin
          level = int'($urandom_range(65535)) - 32768;
          case ($urandom_range(3))
            0:       spread = 0;
            1:       spread = 40;
            2:       spread = 2000;
            default: spread = 65535;
          endcase
        end
        if ($urandom_range(99) < 15)
          cur = int'($urandom_range(65535)) - 32768;
        else
          cur = level + int'($urandom_range(2 * spread)) - spread;
        if (window_slot != WINDOW - 1 || $urandom_range(99) < 15)
          want = int'($urandom_range(65535)) - 32768;
        else if ($urandom_range(99) < 20)
          want = 0;
        else
          want = level + int'($urandom_range(128)) - 64;
        send_item(make_item(cur, want));
      end
    end

    // Full-scale phase at full rate: a few windows push the largest positive
    // error into the integrator at the largest gain, then two windows of the
    // largest negative error pull it back.
    wait_until_settled();
    write_reg(CFG_GAIN, 16'hFFFF);
    write_reg(CFG_LIMIT, 16'd32767);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (SAT_WINDOWS * WINDOW) send_item(make_item(32767, -32768));
    repeat (2 * WINDOW) send_item(make_item(-32768, 32767));

    wait_until_settled();

    $display("Run covered %0d samples and %0d checked results over %0d register settings.",
             sb.samples_seen, sb.drives_checked, NUM_PHASES + 2);
    $display("Windows with a zero target: %0d; windows at the integrator limit: %0d.",
             sb.zero_target_windows, sb.integ_limit_hits);
    if (sb.mismatches == 0) begin
      $display("averaged_current_integral_control: match");
    end else begin
      $display("averaged_current_integral_control: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/acic_pkg.sv
design/averaged_current_integral_control.sv
verif/acic_tb_pkg.sv
verif/tb.sv
